// ===== rtl/box_blur_3x3_rgb_core_assert.svh =====
// Assertion macros used by the port-level checker of the blur core
`ifndef BOX_BLUR_3X3_RGB_CORE_ASSERT_SVH
`define BOX_BLUR_3X3_RGB_CORE_ASSERT_SVH

// same-cycle implication, off while reset is low
`define BB3_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define BB3_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// what must hold in the cycle after reset is sampled low
`define BB3_ASSERT_RST(lbl, clk, rst_n, cons, msg) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bb3_pkg.sv =====
// Types and constants shared by the 3x3 box blur core
`default_nettype none

package bb3_pkg;

    localparam int CH_W = 8;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    // one line-store entry: the pixel two lines up and one line up
    typedef struct packed {
        t_rgb upper;
        t_rgb middle;
    } t_line;

    // window rows or columns that fall outside the frame
    typedef struct packed {
        logic top;
        logic bot;
        logic left;
        logic right;
    } t_mask;

    typedef struct packed {
        logic  first;
        logic  out_v;
        logic  frame_end;
        t_mask mask;
    } t_ctl;

    localparam logic REQ_PIXEL = 1'b0;

    localparam int CFG_AW    = 3;
    localparam int CFG_VAL_W = 11;
    localparam int APB_DW    = 32;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam int RESET_WIDTH  = 800;
    localparam int RESET_HEIGHT = 600;

    localparam int Q_DEPTH = 4;

    // nine 8-bit taps fit in 12 bits; x/9 == (x*7282)>>16 for x < 4096/1.7
    localparam int             SUM_W      = 12;
    localparam int             PROD_W     = 25;
    localparam logic [12:0]    DIV9_MUL   = 13'd7282;
    localparam int             DIV9_SHIFT = 16;
    localparam logic [CH_W-1:0] ALPHA     = 8'hFF;

endpackage

`default_nettype wire

// ===== rtl/bb3_req_if.sv =====
// Input channel of the blur core: one pixel or flush item per beat
`default_nettype none

interface bb3_req_if;
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [bb3_pkg::CH_W-1:0] in_red;
    logic [bb3_pkg::CH_W-1:0] in_green;
    logic [bb3_pkg::CH_W-1:0] in_blue;

    modport source (output valid, req_type, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, req_type, in_red, in_green, in_blue, output ready);
endinterface

`default_nettype wire

// ===== rtl/bb3_rsp_if.sv =====
// Output channel of the blur core: one blurred pixel per beat
`default_nettype none

interface bb3_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_pixel;
    logic        frame_end;

    modport source (output valid, out_pixel, frame_end, input ready);
    modport sink   (input valid, out_pixel, frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/bb3_fifo.sv =====
// Small flop queue between the classifying front and the filter back end
`default_nettype none

module bb3_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data,
    input  wire logic             i_pop
);

    localparam int AW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [NW-1:0]    r_count, n_count;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + NW'(1);
            2'b01:   n_count = r_count - NW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bb3_front.sv =====
// Front end: frame registers, stream position and per-beat classification
`default_nettype none

module bb3_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    bb3_req_if.sink                                i_req,
    input  wire logic                              i_q_full,
    output logic                                   o_push,
    output bb3_pkg::t_ctl                          o_ctl,
    output bb3_pkg::t_rgb                          o_pix,
    output logic [$clog2(MAX_WIDTH)-1:0]           o_col,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bb3_pkg::CFG_AW-1:0]        paddr,
    input  wire logic [bb3_pkg::APB_DW-1:0]        pwdata,
    output logic      [bb3_pkg::APB_DW-1:0]        prdata,
    output logic                                   pready
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int QRW = $clog2(MAX_HEIGHT);
    localparam int RST_W = (bb3_pkg::RESET_WIDTH > MAX_WIDTH) ?
                           MAX_WIDTH : bb3_pkg::RESET_WIDTH;
    localparam int RST_H = (bb3_pkg::RESET_HEIGHT > MAX_HEIGHT) ?
                           MAX_HEIGHT : bb3_pkg::RESET_HEIGHT;

    logic [WW-1:0]  r_width, n_width;
    logic [HW-1:0]  r_height, n_height;
    logic [CW-1:0]  r_col, n_col;
    logic [RW-1:0]  r_row, n_row;
    logic [CW-1:0]  r_qc, n_qc;
    logic [QRW-1:0] r_qr, n_qr;

    logic                           cfg_wr;
    logic                           cfg_idx;
    logic [bb3_pkg::CFG_VAL_W-1:0]  cfg_val;
    logic [WW-1:0]                  w_clamp;
    logic [HW-1:0]                  h_clamp;
    logic                           col_last;
    logic                           qc_last;
    logic                           qr_last;
    logic                           in_frame;
    logic                           out_v;
    logic                           frame_end;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[bb3_pkg::CFG_AW-1];
    assign cfg_val = pwdata[bb3_pkg::CFG_VAL_W-1:0];
    assign pready  = 1'b1;

    always_comb begin
        unique case (cfg_idx)
            bb3_pkg::REG_FRAME_WIDTH:  prdata = bb3_pkg::APB_DW'(r_width);
            bb3_pkg::REG_FRAME_HEIGHT: prdata = bb3_pkg::APB_DW'(r_height);
            default:                   prdata = '0;
        endcase
    end

    // zero reads as one, anything above the maximum saturates
    always_comb begin
        priority if (cfg_val == '0) begin
            w_clamp = WW'(1);
        end else if (int'(cfg_val) > MAX_WIDTH) begin
            w_clamp = WW'(MAX_WIDTH);
        end else begin
            w_clamp = WW'(cfg_val);
        end
        priority if (cfg_val == '0) begin
            h_clamp = HW'(1);
        end else if (int'(cfg_val) > MAX_HEIGHT) begin
            h_clamp = HW'(MAX_HEIGHT);
        end else begin
            h_clamp = HW'(cfg_val);
        end
    end

    assign col_last  = (WW'(r_col) + WW'(1)) == r_width;
    assign qc_last   = (WW'(r_qc) + WW'(1)) == r_width;
    assign qr_last   = (HW'(r_qr) + HW'(1)) == r_height;
    assign in_frame  = r_row < RW'(r_height);
    // results start once a line and one pixel have gone in
    assign out_v     = (r_row > RW'(1)) || ((r_row == RW'(1)) && (r_col != '0));
    assign frame_end = out_v && qc_last && qr_last;

    assign i_req.ready = !i_q_full;
    assign o_push      = i_req.valid && !i_q_full;
    assign o_col       = r_col;

    always_comb begin
        o_ctl.first      = (r_row == '0) && (r_col == '0);
        o_ctl.out_v      = out_v;
        o_ctl.frame_end  = frame_end;
        o_ctl.mask.top   = (r_qr == '0);
        o_ctl.mask.bot   = qr_last;
        o_ctl.mask.left  = (r_qc == '0);
        o_ctl.mask.right = qc_last;
        // flush beats and anything below the last line go in as black
        if ((i_req.req_type == bb3_pkg::REQ_PIXEL) && in_frame) begin
            o_pix.red   = i_req.in_red;
            o_pix.green = i_req.in_green;
            o_pix.blue  = i_req.in_blue;
        end else begin
            o_pix = '0;
        end
    end

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_col    = r_col;
        n_row    = r_row;
        n_qc     = r_qc;
        n_qr     = r_qr;
        priority if (cfg_wr) begin
            if (cfg_idx == bb3_pkg::REG_FRAME_WIDTH) begin
                n_width = w_clamp;
            end else begin
                n_height = h_clamp;
            end
            n_col = '0;
            n_row = '0;
            n_qc  = '0;
            n_qr  = '0;
        end else if (o_push && frame_end) begin
            n_col = '0;
            n_row = '0;
            n_qc  = '0;
            n_qr  = '0;
        end else if (o_push) begin
            if (col_last) begin
                n_col = '0;
                n_row = r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
            if (out_v) begin
                if (qc_last) begin
                    n_qc = '0;
                    n_qr = r_qr + QRW'(1);
                end else begin
                    n_qc = r_qc + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WW'(RST_W);
            r_height <= HW'(RST_H);
            r_col    <= '0;
            r_row    <= '0;
            r_qc     <= '0;
            r_qr     <= '0;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
            r_qc     <= n_qc;
            r_qr     <= n_qr;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bb3_back.sv =====
// Back end: line store, 3x3 window, masked sums, divide by nine, output register
`default_nettype none

module bb3_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_q_valid,
    input  wire bb3_pkg::t_ctl                  i_q_ctl,
    input  wire bb3_pkg::t_rgb                  i_q_pix,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]   i_q_col,
    output logic                                o_q_pop,
    bb3_rsp_if.source                           o_rsp
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int SW = bb3_pkg::SUM_W;
    localparam int PW = bb3_pkg::PROD_W;

    // stage A: beat popped, line-store read in flight
    logic            r_a_v;
    bb3_pkg::t_ctl   r_a_ctl;
    bb3_pkg::t_rgb   r_a_pix;
    logic [CW-1:0]   r_a_col;

    bb3_pkg::t_line  r_line [MAX_WIDTH];
    bb3_pkg::t_line  r_rd;
    bb3_pkg::t_line  r_byp_data;
    logic            r_byp;
    bb3_pkg::t_line  rd;
    bb3_pkg::t_line  wdata;

    // stage S: the window itself
    bb3_pkg::t_rgb   r_win [3][3];
    bb3_pkg::t_rgb   n_win [3][3];
    logic            r_s_v;
    bb3_pkg::t_mask  r_s_mask;
    logic            r_s_end;

    // stage D: channel sums
    logic            r_d_v;
    logic [SW-1:0]   r_d_sum_r, r_d_sum_g, r_d_sum_b;
    logic            r_d_end;
    logic [SW-1:0]   n_sum_r, n_sum_g, n_sum_b;

    // stage O: result register
    logic            r_o_v;
    logic [31:0]     r_o_pixel;
    logic            r_o_end;

    logic            o_free, d_free, s_free, a_free, a_adv;
    logic [2:0]      row_ok, col_ok;
    logic [SW-1:0]   row_r [3];
    logic [SW-1:0]   row_g [3];
    logic [SW-1:0]   row_b [3];
    logic [PW-1:0]   prod_r, prod_g, prod_b;

    assign o_free  = !r_o_v || o_rsp.ready;
    assign d_free  = !r_d_v || o_free;
    assign s_free  = !r_s_v || d_free;
    assign a_free  = !r_a_v || s_free;
    assign a_adv   = r_a_v && s_free;
    assign o_q_pop = i_q_valid && a_free;

    assign rd           = r_byp ? r_byp_data : r_rd;
    assign wdata.upper  = rd.middle;
    assign wdata.middle = r_a_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (a_free) begin
            r_a_v <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_a_ctl <= i_q_ctl;
            r_a_pix <= i_q_pix;
            r_a_col <= i_q_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_line[r_a_col] <= wdata;
        end
    end

    // forward the entry being written when the next beat hits the same column
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rd       <= r_line[i_q_col];
            r_byp      <= a_adv && (r_a_col == i_q_col);
            r_byp_data <= wdata;
        end
    end

    // shift left and load the right column; a frame's first beat starts from black
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            if (r_a_ctl.first) begin
                n_win[r][0] = '0;
                n_win[r][1] = '0;
            end else begin
                n_win[r][0] = r_win[r][1];
                n_win[r][1] = r_win[r][2];
            end
        end
        n_win[0][2] = rd.upper;
        n_win[1][2] = rd.middle;
        n_win[2][2] = r_a_pix;
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_win    <= n_win;
            r_s_mask <= r_a_ctl.mask;
            r_s_end  <= r_a_ctl.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else if (s_free) begin
            r_s_v <= a_adv && r_a_ctl.out_v;
        end
    end

    // drop taps outside the frame
    assign row_ok = {!r_s_mask.bot, 1'b1, !r_s_mask.top};
    assign col_ok = {!r_s_mask.right, 1'b1, !r_s_mask.left};

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            row_r[r] = '0;
            row_g[r] = '0;
            row_b[r] = '0;
            for (int c = 0; c < 3; c++) begin
                if (row_ok[r] && col_ok[c]) begin
                    row_r[r] = row_r[r] + SW'(r_win[r][c].red);
                    row_g[r] = row_g[r] + SW'(r_win[r][c].green);
                    row_b[r] = row_b[r] + SW'(r_win[r][c].blue);
                end
            end
        end
        n_sum_r = row_r[0] + row_r[1] + row_r[2];
        n_sum_g = row_g[0] + row_g[1] + row_g[2];
        n_sum_b = row_b[0] + row_b[1] + row_b[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (d_free) begin
            r_d_v <= r_s_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_free && r_s_v) begin
            r_d_sum_r <= n_sum_r;
            r_d_sum_g <= n_sum_g;
            r_d_sum_b <= n_sum_b;
            r_d_end   <= r_s_end;
        end
    end

    // divide by nine through the reciprocal
    assign prod_r = PW'(r_d_sum_r) * PW'(bb3_pkg::DIV9_MUL);
    assign prod_g = PW'(r_d_sum_g) * PW'(bb3_pkg::DIV9_MUL);
    assign prod_b = PW'(r_d_sum_b) * PW'(bb3_pkg::DIV9_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (o_free) begin
            r_o_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && r_d_v) begin
            r_o_pixel <= {prod_r[bb3_pkg::DIV9_SHIFT +: bb3_pkg::CH_W],
                          prod_g[bb3_pkg::DIV9_SHIFT +: bb3_pkg::CH_W],
                          prod_b[bb3_pkg::DIV9_SHIFT +: bb3_pkg::CH_W],
                          bb3_pkg::ALPHA};
            r_o_end   <= r_d_end;
        end
    end

    assign o_rsp.valid     = r_o_v;
    assign o_rsp.out_pixel = r_o_pixel;
    assign o_rsp.frame_end = r_o_end;

endmodule

`default_nettype wire

// ===== rtl/box_blur_3x3_rgb_core.sv =====
// Streaming 3x3 box blur over an RGB frame: top level
//
// i_req takes one beat per pixel in raster order (req_type 0) or a flush beat
// (req_type 1); after a frame's last pixel send frame_width+1 flush beats to
// drain the bottom line. o_rsp gives one RGBA8888 beat (alpha 0xFF) per frame
// pixel, the average of its in-frame 3x3 neighbours, out-of-frame ones as
// zero, always divided by nine; frame_end marks the last beat of a frame.
// The result for a pixel is caused by the input beat frame_width+1 places
// later; it then passes the queue and stages A, S, D, O. Throughput is one
// beat per cycle while o_rsp does not stall: the line store is one read and
// one write port per cycle, with a one-entry forward for 1-pixel-wide frames.
// Frame size lives in two APB registers (width at 0x0, height at 0x4); a
// write restarts the frame and must be made while the core is idle.
// Reset (synchronous, active low) restores 800x600 and empties the pipeline;
// the line store is not cleared, as border masking hides unwritten entries.
// When o_rsp stalls, the back end holds, then the 4-deep queue fills and
// i_req.ready falls.
`default_nettype none

module box_blur_3x3_rgb_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    bb3_req_if.sink                          i_req,
    bb3_rsp_if.source                        o_rsp,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bb3_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [bb3_pkg::APB_DW-1:0]  pwdata,
    output logic      [bb3_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int QW = $bits(bb3_pkg::t_ctl) + $bits(bb3_pkg::t_rgb) + CW;

    logic           push, q_full, q_valid, pop;
    bb3_pkg::t_ctl  f_ctl, q_ctl;
    bb3_pkg::t_rgb  f_pix, q_pix;
    logic [CW-1:0]  f_col, q_col;
    logic [QW-1:0]  q_in, q_out;

    bb3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_push   (push),
        .o_ctl    (f_ctl),
        .o_pix    (f_pix),
        .o_col    (f_col),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    assign q_in = {f_ctl, f_pix, f_col};

    bb3_fifo #(
        .WIDTH (QW),
        .DEPTH (bb3_pkg::Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (pop)
    );

    assign {q_ctl, q_pix, q_col} = q_out;

    bb3_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_ctl   (q_ctl),
        .i_q_pix   (q_pix),
        .i_q_col   (q_col),
        .o_q_pop   (pop),
        .o_rsp     (o_rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/bb3_chk.sv =====
// Port-level checker for the blur core, bound to the top level
`default_nettype none

`include "box_blur_3x3_rgb_core_assert.svh"

module bb3_chk (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [31:0] i_out_pixel,
    input  wire logic        i_out_end
);

    `BB3_ASSERT_RST(a_rst_empty, i_clk, i_rst_n, !i_out_valid, "output valid after reset")
    `BB3_ASSERT_NXT(a_hold_valid, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "stalled beat dropped")
    `BB3_ASSERT_NXT(a_hold_data, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_pixel) && $stable(i_out_end), "stalled beat changed")
    `BB3_ASSERT_IMP(a_alpha, i_clk, i_rst_n, i_out_valid, i_out_pixel[7:0] == bb3_pkg::ALPHA, "alpha byte not opaque")

endmodule

bind box_blur_3x3_rgb_core bb3_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_pixel (o_rsp.out_pixel),
    .i_out_end   (o_rsp.frame_end)
);

`default_nettype wire
